// ===== hw/rtl/eighty_column_card_bus_interface_macros.svh =====
// ============================================================================
// Assertion macros for the 80-column card bus interface
// Immediate-style wrappers around concurrent assertions; empty in synthesis.
// ============================================================================
`ifndef EIGHTY_COLUMN_CARD_BUS_INTERFACE_MACROS_SVH
`define EIGHTY_COLUMN_CARD_BUS_INTERFACE_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ECCBI_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define ECCBI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ECCBI_ASSERT(label, clk, rst_n, ante, cons, msg)
`define ECCBI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/eccbi_pkg.sv =====
// ============================================================================
// eccbi_pkg
// Shared types and constants of the 80-column card bus interface.
// ============================================================================
package eccbi_pkg;

    localparam int unsigned SLOT_NUMBER_DEF = 3;
    localparam int unsigned COLUMNS_DEF     = 80;

    localparam int unsigned VRAM_BYTES  = 2048;
    localparam int unsigned VRAM_AW     = 11;
    localparam int unsigned ROM_BYTES   = 1024;
    localparam int unsigned ROM_AW      = 10;
    localparam int unsigned NUM_REGS    = 18;
    localparam int unsigned QUEUE_DEPTH = 2;

    // reciprocal division of a screen offset by the column count
    localparam int unsigned DIV_SHIFT = 18;
    localparam int unsigned RECIP_W   = 13;

    // window map
    localparam logic [10:0] WIN_RAM_LO = 11'h400;
    localparam logic [10:0] WIN_GAP    = 11'h600;

    // controller register indices
    localparam logic [4:0] REG_CUR_START = 5'd10;
    localparam logic [4:0] REG_CUR_END   = 5'd11;
    localparam logic [4:0] REG_START_HI  = 5'd12;
    localparam logic [4:0] REG_START_LO  = 5'd13;
    localparam logic [4:0] REG_CURSOR_HI = 5'd14;
    localparam logic [4:0] REG_CURSOR_LO = 5'd15;

    localparam logic [7:0] REG_DEFAULTS [NUM_REGS] = '{
        8'h7b, 8'h50, 8'h62, 8'h29, 8'h1b, 8'h08, 8'h18, 8'h19, 8'h00,
        8'h08, 8'hc0, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [3:0] CUR_TOP_RST = 4'd0;
    localparam logic [3:0] CUR_BOT_RST = 4'd8;

    // bus access codes
    typedef enum logic [2:0] {
        OP_IO_RD   = 3'd0,
        OP_IO_WR   = 3'd1,
        OP_WIN_RD  = 3'd2,
        OP_WIN_WR  = 3'd3,
        OP_SLOT_RD = 3'd4,
        OP_ROM_LD  = 3'd5
    } t_op;

    // classified access
    typedef enum logic [2:0] {
        K_NOP    = 3'd0,
        K_IO_RD  = 3'd1,
        K_IO_WR  = 3'd2,
        K_ROM_RD = 3'd3,
        K_RAM_RD = 3'd4,
        K_RAM_WR = 3'd5,
        K_ROM_LD = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              io_sel;    // 1: data register, 0: index
        logic [1:0]        bank;
        logic [8:0]        ram_off;
        logic [ROM_AW-1:0] rom_addr;
        logic [7:0]        data;
    } t_cmd;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_REG  = 2'd1,
        SRC_RAM  = 2'd2,
        SRC_ROM  = 2'd3
    } t_rd_src;

endpackage

// ===== hw/rtl/eccbi_front.sv =====
// ============================================================================
// eccbi_front
// Accepts bus accesses and classifies them into queue commands.
// ============================================================================
module eccbi_front #(
    parameter int unsigned SLOT_NUMBER = eccbi_pkg::SLOT_NUMBER_DEF
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_op,
    input  logic [10:0]       i_addr,
    input  logic [7:0]        i_data,
    input  logic              i_full,
    input  logic              i_busy,
    output logic              o_push,
    output eccbi_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] SLOT_PAGE = 2'(SLOT_NUMBER);

    assign o_ready = !i_full && !i_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = eccbi_pkg::K_NOP;
        o_cmd.io_sel   = i_addr[0];
        o_cmd.bank     = i_addr[3:2];
        o_cmd.ram_off  = i_addr[8:0];
        o_cmd.rom_addr = i_addr[eccbi_pkg::ROM_AW-1:0];
        o_cmd.data     = i_data;
        case (eccbi_pkg::t_op'(i_op))
            eccbi_pkg::OP_IO_RD: begin
                o_cmd.kind = eccbi_pkg::K_IO_RD;
            end
            eccbi_pkg::OP_IO_WR: begin
                o_cmd.kind = eccbi_pkg::K_IO_WR;
            end
            eccbi_pkg::OP_WIN_RD: begin
                if (i_addr < eccbi_pkg::WIN_RAM_LO) begin
                    o_cmd.kind = eccbi_pkg::K_ROM_RD;
                end else if (i_addr < eccbi_pkg::WIN_GAP) begin
                    o_cmd.kind = eccbi_pkg::K_RAM_RD;
                end
            end
            eccbi_pkg::OP_WIN_WR: begin
                if (i_addr >= eccbi_pkg::WIN_RAM_LO && i_addr < eccbi_pkg::WIN_GAP) begin
                    o_cmd.kind = eccbi_pkg::K_RAM_WR;
                end
            end
            eccbi_pkg::OP_SLOT_RD: begin
                o_cmd.kind     = eccbi_pkg::K_ROM_RD;
                o_cmd.rom_addr = {SLOT_PAGE, i_addr[7:0]};
            end
            eccbi_pkg::OP_ROM_LD: begin
                o_cmd.kind = eccbi_pkg::K_ROM_LD;
            end
            default: begin
                o_cmd.kind = eccbi_pkg::K_NOP;
            end
        endcase
    end

endmodule

// ===== hw/rtl/eccbi_queue.sv =====
// ============================================================================
// eccbi_queue
// Short command queue between the front and back ends.
// ============================================================================
`include "eighty_column_card_bus_interface_macros.svh"

module eccbi_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  eccbi_pkg::t_cmd   i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output eccbi_pkg::t_cmd   o_cmd,
    input  logic              i_pop
);

    localparam int unsigned DEPTH = eccbi_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    eccbi_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `ECCBI_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop && 1'b0, "queue push while full")
    `ECCBI_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "queue pop while empty")

endmodule

// ===== hw/rtl/eccbi_posdiv.sv =====
// ============================================================================
// eccbi_posdiv
// Splits an 11-bit screen offset into row and column, two stages.
// ============================================================================
module eccbi_posdiv #(
    parameter int unsigned COLUMNS = eccbi_pkg::COLUMNS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [10:0] i_off,
    output logic [4:0]  o_row,
    output logic [6:0]  o_col
);

    localparam int unsigned AW     = eccbi_pkg::VRAM_AW;
    localparam int unsigned RW     = eccbi_pkg::RECIP_W;
    localparam int unsigned SH     = eccbi_pkg::DIV_SHIFT;
    localparam int unsigned PROD_W = AW + RW;
    localparam int unsigned Q_W    = PROD_W - SH;
    // ceil(2^SH / COLUMNS): exact quotient for all offsets below 2^AW
    localparam int unsigned RECIP  = ((1 << SH) + COLUMNS - 1) / COLUMNS;
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
    localparam logic [6:0]    COLS_C  = 7'(COLUMNS);
    localparam int unsigned QD_W   = Q_W + 7;

    logic [AW-1:0]     r_x;
    logic [PROD_W-1:0] r_p;
    logic [Q_W-1:0]    w_q;
    logic [QD_W-1:0]   w_qd;
    logic [AW-1:0]     w_rem;

    assign w_q   = r_p[PROD_W-1:SH];
    assign w_qd  = QD_W'(w_q) * QD_W'(COLS_C);
    assign w_rem = r_x - w_qd[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= i_off;
            r_p   <= PROD_W'(i_off) * PROD_W'(RECIP_C);
            o_row <= w_q[4:0];
            o_col <= w_rem[6:0];
        end
    end

endmodule

// ===== hw/rtl/eccbi_back.sv =====
// ============================================================================
// eccbi_back
// Executes queued accesses: controller registers, video RAM, firmware ROM,
// and the three-stage result pipeline with the output register.
// ============================================================================
`include "eighty_column_card_bus_interface_macros.svh"

module eccbi_back #(
    parameter int unsigned COLUMNS = eccbi_pkg::COLUMNS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  eccbi_pkg::t_cmd   i_cmd,
    output logic              o_cmd_pop,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_read_data,
    output logic              o_draw_valid,
    output logic [4:0]        o_draw_row,
    output logic [6:0]        o_draw_col,
    output logic [7:0]        o_draw_char,
    output logic [4:0]        o_cursor_row,
    output logic [6:0]        o_cursor_col,
    output logic [3:0]        o_cursor_top,
    output logic [3:0]        o_cursor_bottom,
    output logic              o_redraw
);

    localparam int unsigned NREG  = eccbi_pkg::NUM_REGS;
    localparam int unsigned AW    = eccbi_pkg::VRAM_AW;
    localparam int unsigned RAW   = eccbi_pkg::ROM_AW;

    // cursor scan-line decode: {top, bottom}
    function automatic logic [7:0] f_bounds(input logic [7:0] r10, input logic [7:0] r11);
        logic [3:0] top;
        logic [3:0] bot;
        top = 4'd0;
        bot = 4'd12;
        for (int b = 0; b < 7; b++) begin
            if (r10[b]) top = 4'(6 - b);
        end
        for (int b = 7; b >= 0; b--) begin
            if (r11[b]) bot = 4'(12 - b);
        end
        if (top >= bot) begin
            top = 4'd0;
            bot = 4'd12;
        end
        return {top, bot};
    endfunction

    // architectural state
    logic [7:0]      r_regs [NREG];
    logic [7:0]      n_regs [NREG];
    logic [4:0]      r_index, n_index;
    logic [1:0]      r_bank, n_bank;
    logic [3:0]      r_top, n_top;
    logic [3:0]      r_bot, n_bot;

    // memories
    logic [7:0]      r_vram [eccbi_pkg::VRAM_BYTES];
    logic [7:0]      r_rom  [eccbi_pkg::ROM_BYTES];
    logic [7:0]      r_vram_q;
    logic [7:0]      r_rom_q;

    // clearing pass
    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;

    // pipeline
    logic            w_adv, w_pop;
    logic [AW-1:0]   w_va, w_draw_off, w_cur_off, w_ram_wa;
    logic [7:0]      w_ram_wd, w_reg_q;
    logic            w_ram_we, w_ram_re, w_rom_we, w_rom_re;
    logic            w_idx_ok, w_bnd_upd, w_redraw;
    logic [7:0]      w_bounds;
    eccbi_pkg::t_rd_src w_src;

    logic               r1_valid, r2_valid;
    eccbi_pkg::t_rd_src r1_src;
    logic [7:0]         r1_reg_q, r1_char, r2_rd, r2_char;
    logic               r1_dv, r1_redraw, r2_dv, r2_redraw;
    logic [3:0]         r1_top, r1_bot, r2_top, r2_bot;
    logic [AW-1:0]      r1_draw_off, r1_cur_off;

    assign w_adv     = !o_valid || i_ready;
    assign w_pop     = w_adv && i_cmd_valid && !r_clearing;
    assign o_cmd_pop = w_pop;
    assign o_busy    = r_clearing;

    assign w_idx_ok   = (r_index < 5'(NREG));
    assign w_va       = {r_bank, i_cmd.ram_off};
    assign w_draw_off = w_va - {r_regs[eccbi_pkg::REG_START_HI][2:0],
                                r_regs[eccbi_pkg::REG_START_LO]};

    // register file, index and bank updates
    always_comb begin
        n_regs    = r_regs;
        n_index   = r_index;
        n_bank    = r_bank;
        n_top     = r_top;
        n_bot     = r_bot;
        w_reg_q   = 8'd0;
        w_redraw  = 1'b0;
        w_bnd_upd = 1'b0;
        w_src     = eccbi_pkg::SRC_ZERO;
        if (w_pop) begin
            case (i_cmd.kind)
                eccbi_pkg::K_IO_RD: begin
                    n_bank = i_cmd.bank;
                    if (i_cmd.io_sel) begin
                        w_src = eccbi_pkg::SRC_REG;
                        if (w_idx_ok) w_reg_q = r_regs[r_index];
                    end
                end
                eccbi_pkg::K_IO_WR: begin
                    n_bank = i_cmd.bank;
                    if (i_cmd.io_sel) begin
                        if (w_idx_ok) begin
                            n_regs[r_index] = i_cmd.data;
                            w_bnd_upd = (r_index == eccbi_pkg::REG_CUR_START) ||
                                        (r_index == eccbi_pkg::REG_CUR_END);
                            w_redraw  = (r_index == eccbi_pkg::REG_START_LO);
                        end
                    end else begin
                        n_index = i_cmd.data[4:0];
                    end
                end
                eccbi_pkg::K_ROM_RD: w_src = eccbi_pkg::SRC_ROM;
                eccbi_pkg::K_RAM_RD: w_src = eccbi_pkg::SRC_RAM;
                default: begin
                    w_src = eccbi_pkg::SRC_ZERO;
                end
            endcase
        end
        w_bounds = f_bounds(n_regs[eccbi_pkg::REG_CUR_START], n_regs[eccbi_pkg::REG_CUR_END]);
        if (w_bnd_upd) begin
            n_top = w_bounds[7:4];
            n_bot = w_bounds[3:0];
        end
        w_cur_off = {n_regs[eccbi_pkg::REG_CURSOR_HI][2:0], n_regs[eccbi_pkg::REG_CURSOR_LO]}
                  - {n_regs[eccbi_pkg::REG_START_HI][2:0], n_regs[eccbi_pkg::REG_START_LO]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs  <= eccbi_pkg::REG_DEFAULTS;
            r_index <= 5'd0;
            r_bank  <= 2'd0;
            r_top   <= eccbi_pkg::CUR_TOP_RST;
            r_bot   <= eccbi_pkg::CUR_BOT_RST;
        end else begin
            r_regs  <= n_regs;
            r_index <= n_index;
            r_bank  <= n_bank;
            r_top   <= n_top;
            r_bot   <= n_bot;
        end
    end

    // video RAM preset sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) r_clearing <= 1'b0;
        end
    end

    assign w_ram_we = r_clearing || (w_pop && i_cmd.kind == eccbi_pkg::K_RAM_WR);
    assign w_ram_re = w_pop && i_cmd.kind == eccbi_pkg::K_RAM_RD;
    assign w_rom_we = w_pop && i_cmd.kind == eccbi_pkg::K_ROM_LD;
    assign w_rom_re = w_pop && i_cmd.kind == eccbi_pkg::K_ROM_RD;
    assign w_ram_wa = r_clearing ? r_clr_addr : w_va;
    assign w_ram_wd = r_clearing ? r_clr_addr[7:0] : i_cmd.data;

    always_ff @(posedge i_clk) begin
        if (w_ram_we) r_vram[w_ram_wa] <= w_ram_wd;
        if (w_ram_re) r_vram_q <= r_vram[w_va];
    end

    always_ff @(posedge i_clk) begin
        if (w_rom_we) r_rom[i_cmd.rom_addr[RAW-1:0]] <= i_cmd.data;
        if (w_rom_re) r_rom_q <= r_rom[i_cmd.rom_addr[RAW-1:0]];
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= w_pop;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_src      <= w_src;
            r1_reg_q    <= w_reg_q;
            r1_dv       <= w_pop && i_cmd.kind == eccbi_pkg::K_RAM_WR;
            r1_char     <= (w_pop && i_cmd.kind == eccbi_pkg::K_RAM_WR) ? i_cmd.data : 8'd0;
            r1_draw_off <= (w_pop && i_cmd.kind == eccbi_pkg::K_RAM_WR) ? w_draw_off : '0;
            r1_cur_off  <= w_cur_off;
            r1_redraw   <= w_redraw;
            r1_top      <= n_top;
            r1_bot      <= n_bot;

            case (r1_src)
                eccbi_pkg::SRC_REG: r2_rd <= r1_reg_q;
                eccbi_pkg::SRC_RAM: r2_rd <= r_vram_q;
                eccbi_pkg::SRC_ROM: r2_rd <= r_rom_q;
                default:            r2_rd <= 8'd0;
            endcase
            r2_dv     <= r1_dv;
            r2_char   <= r1_char;
            r2_redraw <= r1_redraw;
            r2_top    <= r1_top;
            r2_bot    <= r1_bot;

            o_read_data     <= r2_rd;
            o_draw_valid    <= r2_dv;
            o_draw_char     <= r2_char;
            o_redraw        <= r2_redraw;
            o_cursor_top    <= r2_top;
            o_cursor_bottom <= r2_bot;
        end
    end

    eccbi_posdiv #(
        .COLUMNS (COLUMNS)
    ) u_draw_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_off (r1_draw_off),
        .o_row (o_draw_row),
        .o_col (o_draw_col)
    );

    eccbi_posdiv #(
        .COLUMNS (COLUMNS)
    ) u_cursor_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_off (r1_cur_off),
        .o_row (o_cursor_row),
        .o_col (o_cursor_col)
    );

    `ECCBI_ASSERT(a_bounds_order, i_clk, i_rst_n, 1'b1, r_top < r_bot, "cursor top not above bottom")
    `ECCBI_ASSERT(a_draw_no_read, i_clk, i_rst_n, o_valid && o_draw_valid, o_read_data == 8'd0 && !o_redraw, "draw result carries read data or redraw")
    `ECCBI_ASSERT(a_clear_empty, i_clk, i_rst_n, r_clearing, !r1_valid && !r2_valid && !o_valid, "work in flight during RAM preset")
    `ECCBI_ASSERT_NXT(a_clear_once, i_clk, i_rst_n, !r_clearing, !r_clearing, "RAM preset restarted")

endmodule

// ===== hw/rtl/eighty_column_card_bus_interface.sv =====
// ============================================================================
// eighty_column_card_bus_interface
// Bus side of an 80-column video card with a 6845-style CRT controller.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_ready) carries one bus access per transfer:
//   i_op selects io read/write, window read/write, slot ROM read or ROM load;
//   i_addr and i_data give the offset and write byte.
//   Output channel (o_valid / i_ready) returns exactly one result transfer
//   per access: read byte, character-write position, cursor position and
//   cursor scan-line bounds, and the redraw flag.
//   Path from acceptance to o_valid with no stall: queue slot, execute with
//   RAM/ROM read, row/column multiply, output register.
//   Throughput: one access per cycle outside receiver stalls and the RAM preset,
//   set by the single RAM/ROM port and the pipelined reciprocal divider.
//   Reset: registers return to controller defaults, index and bank to zero.
//   A sweep over all 2048 addresses then presets the video RAM; o_ready is low meanwhile.
//   Receiver stall: the output register holds and the back end freezes; the
//   front keeps taking accesses until the two-entry queue fills.
// ============================================================================
module eighty_column_card_bus_interface #(
    parameter int unsigned SLOT_NUMBER = eccbi_pkg::SLOT_NUMBER_DEF,
    parameter int unsigned COLUMNS     = eccbi_pkg::COLUMNS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [10:0] i_addr,
    input  logic [7:0]  i_data,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_draw_valid,
    output logic [4:0]  o_draw_row,
    output logic [6:0]  o_draw_col,
    output logic [7:0]  o_draw_char,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic [3:0]  o_cursor_top,
    output logic [3:0]  o_cursor_bottom,
    output logic        o_redraw
);

    eccbi_pkg::t_cmd w_push_cmd;
    eccbi_pkg::t_cmd w_head_cmd;
    logic            w_push, w_full, w_head_valid, w_pop, w_busy;

    // front: takes the transfer and works out what kind of access it is
    eccbi_front #(
        .SLOT_NUMBER (SLOT_NUMBER)
    ) u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .i_addr  (i_addr),
        .i_data  (i_data),
        .i_full  (w_full),
        .i_busy  (w_busy),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // decouples acceptance from execution so a stalled receiver
    // does not immediately back-pressure the bus
    eccbi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd),
        .i_pop   (w_pop)
    );

    // back: owns registers, video RAM and firmware ROM, in access order
    eccbi_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_head_valid),
        .i_cmd           (w_head_cmd),
        .o_cmd_pop       (w_pop),
        .o_busy          (w_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_read_data     (o_read_data),
        .o_draw_valid    (o_draw_valid),
        .o_draw_row      (o_draw_row),
        .o_draw_col      (o_draw_col),
        .o_draw_char     (o_draw_char),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_top    (o_cursor_top),
        .o_cursor_bottom (o_cursor_bottom),
        .o_redraw        (o_redraw)
    );

endmodule

// ===== tb/eighty_column_card_bus_interface_tb.sv =====
// ============================================================================
// eighty_column_card_bus_interface_tb
// Self-checking bench for the card's bus side. A short table of directed bus
// accesses comes first, then constrained-by-hand random traffic. Every result
// transfer is checked against typed-in values or an in-bench model of registers, RAM and ROM.
// ============================================================================
module eighty_column_card_bus_interface_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eccbi_pkg::*;

    localparam int unsigned HALF_PERIOD  = 4;
    localparam int unsigned RESET_CYCLES = 5;
    localparam int unsigned BUSY_ITEMS   = 1450;
    // idle limit covers the RAM preset after reset several times over
    localparam int unsigned IDLE_LIMIT   = 8000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned CALM_STRIDE  = 150;
    localparam int unsigned DRAIN_STRIDE = 500;

    // op codes the block does not decode
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // firmware page served by slot ROM reads
    localparam logic [9:0] SLOT_PAGE  = 10'(SLOT_NUMBER_DEF * 256);
    localparam logic [3:0] CELL_LINES = 4'd12;

    typedef struct packed {
        logic [7:0] read_data;
        logic       draw_valid;
        logic [4:0] draw_row;
        logic [6:0] draw_col;
        logic [7:0] draw_char;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [3:0] cursor_top;
        logic [3:0] cursor_bottom;
        logic       redraw;
    } t_card_result;

    typedef struct packed {
        logic [2:0]   op;
        logic [10:0]  addr;
        logic [7:0]   data;
        logic         fixed;    // 1: result below is the expectation
        t_card_result result;
    } t_access_row;

    localparam t_card_result NO_RESULT = '0;
    // nothing read, cursor at home, reset scan-line bounds
    localparam t_card_result QUIET_AT_RESET = '{8'h00, 1'b0, 5'd0, 7'd0, 8'h00,
        5'd0, 7'd0, CUR_TOP_RST, CUR_BOT_RST, 1'b0};

    localparam int unsigned SCRIPT_ROWS = 27;

    // Directed accesses. Results are typed in only while the card is still in
    // its reset state; the rest go through the model.
    localparam t_access_row ACCESS_SCRIPT [SCRIPT_ROWS] = '{
        // register 0 read straight after reset
        '{OP_IO_RD,   11'h001, 8'h00, 1'b1, '{8'h7b, 1'b0, 5'd0, 7'd0, 8'h00,
            5'd0, 7'd0, CUR_TOP_RST, CUR_BOT_RST, 1'b0}},
        // RAM preset: first and last byte of bank 0
        '{OP_WIN_RD,  11'h400, 8'h00, 1'b1, QUIET_AT_RESET},
        '{OP_WIN_RD,  11'h5ff, 8'h00, 1'b1, '{8'hff, 1'b0, 5'd0, 7'd0, 8'h00,
            5'd0, 7'd0, CUR_TOP_RST, CUR_BOT_RST, 1'b0}},
        // window gap reads zero
        '{OP_WIN_RD,  11'h7ff, 8'h00, 1'b1, QUIET_AT_RESET},
        // index beyond the register file: reads zero, writes dropped
        '{OP_IO_WR,   11'h000, 8'hff, 1'b1, QUIET_AT_RESET},
        '{OP_IO_RD,   11'h7f1, 8'h00, 1'b1, QUIET_AT_RESET},
        '{OP_IO_WR,   11'h001, 8'haa, 1'b1, QUIET_AT_RESET},
        // start address low: only the low five bits of the data pick the index
        '{OP_IO_WR,   11'h000, {3'b111, REG_START_LO}, 1'b1, QUIET_AT_RESET},
        '{OP_IO_WR,   11'h001, 8'h00, 1'b1, '{8'h00, 1'b0, 5'd0, 7'd0, 8'h00,
            5'd0, 7'd0, CUR_TOP_RST, CUR_BOT_RST, 1'b1}},
        // scan-line bounds: top from reg 10, bottom from reg 11, overlap folds
        '{OP_IO_WR,   11'h000, {3'b000, REG_CUR_START}, 1'b0, NO_RESULT},
        '{OP_IO_WR,   11'h001, 8'h7f, 1'b0, NO_RESULT},
        '{OP_IO_WR,   11'h000, {3'b000, REG_CUR_END}, 1'b0, NO_RESULT},
        '{OP_IO_WR,   11'h001, 8'h00, 1'b0, NO_RESULT},
        '{OP_IO_WR,   11'h001, 8'h80, 1'b0, NO_RESULT},
        '{OP_IO_WR,   11'h000, {3'b000, REG_CUR_START}, 1'b0, NO_RESULT},
        '{OP_IO_WR,   11'h001, 8'h01, 1'b0, NO_RESULT},
        // ROM load index wraps to ten bits, then both ROM read paths
        '{OP_ROM_LD,  11'h7ff, 8'ha5, 1'b0, NO_RESULT},
        '{OP_SLOT_RD, 11'h7ff, 8'h00, 1'b0, NO_RESULT},
        '{OP_WIN_RD,  11'h3ff, 8'h00, 1'b0, NO_RESULT},
        // bank 3, character write, then writes outside the RAM window
        '{OP_IO_RD,   11'h00c, 8'h00, 1'b0, NO_RESULT},
        '{OP_WIN_WR,  11'h400, 8'hff, 1'b0, NO_RESULT},
        '{OP_WIN_WR,  11'h3ff, 8'h12, 1'b0, NO_RESULT},
        '{OP_WIN_WR,  11'h600, 8'h34, 1'b0, NO_RESULT},
        // undecoded ops
        '{OP_SPARE_6, 11'h7ff, 8'hff, 1'b0, NO_RESULT},
        '{OP_SPARE_7, 11'h000, 8'h00, 1'b0, NO_RESULT},
        // start address high at its top value
        '{OP_IO_WR,   11'h000, {3'b000, REG_START_HI}, 1'b0, NO_RESULT},
        '{OP_IO_WR,   11'h001, 8'hff, 1'b0, NO_RESULT}
    };

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_op    = '0;
    logic [10:0] i_addr  = '0;
    logic [7:0]  i_data  = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_draw_valid;
    logic [4:0]  o_draw_row;
    logic [6:0]  o_draw_col;
    logic [7:0]  o_draw_char;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic [3:0]  o_cursor_top;
    logic [3:0]  o_cursor_bottom;
    logic        o_redraw;

    // Model of the card state
    logic [7:0]   crtc_shadow [NUM_REGS];
    logic [4:0]   index_shadow;
    logic [1:0]   bank_shadow;
    logic [7:0]   vram_shadow [VRAM_BYTES];
    logic [7:0]   rom_shadow  [ROM_BYTES];
    bit           rom_loaded  [ROM_BYTES];
    logic [9:0]   loaded_rom_idx [$];
    logic [9:0]   loaded_slot_idx [$];
    logic [3:0]   top_shadow;
    logic [3:0]   bot_shadow;

    t_card_result awaited_results [$];
    t_card_result observed;
    t_card_result result_due;

    bit           calm = 1'b0;     // 1: neither side idles
    int unsigned  busy_items = 0;  // accesses that do something
    int unsigned  mismatches = 0;
    int unsigned  strays = 0;
    int unsigned  stall_draw;
    int unsigned  stall_left;
    int unsigned  idle_cycles = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    eighty_column_card_bus_interface u_top (.*);

    assign observed = {o_read_data, o_draw_valid, o_draw_row, o_draw_col, o_draw_char,
                       o_cursor_row, o_cursor_col, o_cursor_top, o_cursor_bottom, o_redraw};

    // Screen offset of a RAM address against the start address (regs 12/13).
    function automatic logic [10:0] screen_offset(input logic [10:0] a);
        logic [31:0] diff;
        diff = 32'h800 + 32'(a)
             - {16'h0, crtc_shadow[REG_START_HI], crtc_shadow[REG_START_LO]};
        return diff[10:0];
    endfunction

    // Top line from the highest set bit of reg 10 (seven bits), bottom from the
    // lowest set bit of reg 11; an empty or inverted span falls back to the
    // whole cell.
    function automatic void decode_cursor_lines();
        logic [6:0] hi;
        logic [7:0] lo;
        logic [3:0] top;
        logic [3:0] bot;
        hi  = crtc_shadow[REG_CUR_START][6:0];
        lo  = crtc_shadow[REG_CUR_END];
        top = 4'd0;
        bot = CELL_LINES;
        if (hi != '0) begin
            while (!hi[6]) begin
                top++;
                hi = hi << 1;
            end
        end
        if (lo != '0) begin
            while (!lo[0]) begin
                bot--;
                lo = lo >> 1;
            end
        end
        if (top >= bot) begin
            top = 4'd0;
            bot = CELL_LINES;
        end
        top_shadow = top;
        bot_shadow = bot;
    endfunction

    // Applies one bus access to the model and returns the result it yields.
    function automatic t_card_result card_response(input logic [2:0] op,
                                                   input logic [10:0] addr,
                                                   input logic [7:0] data);
        t_card_result r;
        logic [10:0]  va;
        logic [10:0]  pos;
        logic [9:0]   ri;
        r = '0;
        case (op)
            OP_IO_RD: begin
                bank_shadow = addr[3:2];
                if (addr[0])
                    r.read_data = (index_shadow < NUM_REGS) ? crtc_shadow[index_shadow] : 8'h00;
            end
            OP_IO_WR: begin
                bank_shadow = addr[3:2];
                if (!addr[0]) begin
                    index_shadow = data[4:0];
                end else if (index_shadow < NUM_REGS) begin
                    crtc_shadow[index_shadow] = data;
                    if (index_shadow == REG_CUR_START || index_shadow == REG_CUR_END)
                        decode_cursor_lines();
                    r.redraw = (index_shadow == REG_START_LO);
                end
            end
            OP_WIN_RD: begin
                if (addr < WIN_RAM_LO)
                    r.read_data = rom_shadow[addr[9:0]];
                else if (addr < WIN_GAP)
                    r.read_data = vram_shadow[{bank_shadow, addr[8:0]}];
            end
            OP_WIN_WR: begin
                if (addr >= WIN_RAM_LO && addr < WIN_GAP) begin
                    va = {bank_shadow, addr[8:0]};
                    vram_shadow[va] = data;
                    pos = screen_offset(va);
                    r.draw_valid = 1'b1;
                    r.draw_row   = 5'(pos / COLUMNS_DEF);
                    r.draw_col   = 7'(pos % COLUMNS_DEF);
                    r.draw_char  = data;
                end
            end
            OP_SLOT_RD: begin
                ri = SLOT_PAGE + {2'b00, addr[7:0]};
                r.read_data = rom_shadow[ri];
            end
            OP_ROM_LD: begin
                ri = addr[9:0];
                rom_shadow[ri] = data;
                if (!rom_loaded[ri]) begin
                    rom_loaded[ri] = 1'b1;
                    loaded_rom_idx.push_back(ri);
                    if (ri[9:8] == SLOT_PAGE[9:8])
                        loaded_slot_idx.push_back(ri);
                end
            end
            default: ;
        endcase
        pos = screen_offset({crtc_shadow[REG_CURSOR_HI][2:0], crtc_shadow[REG_CURSOR_LO]});
        r.cursor_row    = 5'(pos / COLUMNS_DEF);
        r.cursor_col    = 7'(pos % COLUMNS_DEF);
        r.cursor_top    = top_shadow;
        r.cursor_bottom = bot_shadow;
        return r;
    endfunction

    // ROM entries never loaded must not be read: point ROM reads at loaded
    // bytes, or turn the access into a load when nothing suitable exists yet.
    function automatic void steer_rom_read(inout logic [2:0] op, inout logic [10:0] addr);
        logic [9:0] pick;
        if (op == OP_WIN_RD && addr < WIN_RAM_LO) begin
            if (loaded_rom_idx.size() == 0) begin
                op = OP_ROM_LD;
            end else begin
                pick = loaded_rom_idx[$urandom_range(0, loaded_rom_idx.size() - 1)];
                addr = {1'b0, pick};
            end
        end else if (op == OP_SLOT_RD) begin
            if (loaded_slot_idx.size() == 0) begin
                op = OP_ROM_LD;
                addr[9:8] = SLOT_PAGE[9:8];
            end else begin
                pick = loaded_slot_idx[$urandom_range(0, loaded_slot_idx.size() - 1)];
                addr[7:0] = pick[7:0];
            end
        end
    endfunction

    function automatic string describe(input t_card_result r);
        return $sformatf("rd=%02h draw=%0d row=%0d col=%0d ch=%02h cur=%0d,%0d lines=%0d..%0d redraw=%0d",
                         r.read_data, r.draw_valid, r.draw_row, r.draw_col, r.draw_char,
                         r.cursor_row, r.cursor_col, r.cursor_top, r.cursor_bottom, r.redraw);
    endfunction

    // One access transfer: random gap with valid low, then hold valid and the
    // payload until o_ready is seen at an edge. Called at a rising edge and
    // returns at the edge of the transfer. Valid is left high so a back-to-back
    // access only changes the payload.
    task automatic push_access(input logic [2:0] op, input logic [10:0] addr,
                               input logic [7:0] data, input bit fixed,
                               input t_card_result typed);
        int unsigned  gap;
        t_card_result predicted;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_addr  <= addr;
        i_data  <= data;
        do @(posedge i_clk); while (!o_ready);
        predicted = card_response(op, addr, data);
        awaited_results.push_back(fixed ? typed : predicted);
        if (op <= OP_ROM_LD && !(op == OP_WIN_WR && (addr < WIN_RAM_LO || addr >= WIN_GAP)))
            busy_items++;
    endtask

    // Sender holds off until the card has handed back every result.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Result side: after each result transfer, i_ready may drop for a randomly drawn stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b1;
            stall_left <= 0;
        end else if (o_valid && i_ready) begin
            stall_draw = calm ? 0 : $urandom_range(0, 3);
            if (stall_draw != 0) begin
                i_ready    <= 1'b0;
                stall_left <= stall_draw - 1;
            end
        end else if (!i_ready) begin
            if (stall_left == 0)
                i_ready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    // Result checker: each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                strays++;
                if (mismatches + strays <= MAX_REPORTS)
                    $display("unexpected result transfer: %s", describe(observed));
            end else begin
                result_due = awaited_results.pop_front();
                if (observed !== result_due) begin
                    mismatches++;
                    if (mismatches + strays <= MAX_REPORTS) begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  expected %s", describe(result_due));
                        $display("  actual   %s", describe(observed));
                    end
                end
            end
        end
    end

    // Watchdog: too long without a transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("eighty_column_card_bus_interface_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned row;
        int unsigned roll;
        int unsigned burst;
        int unsigned next_calm;
        int unsigned next_drain;
        logic [2:0]  op;
        logic [10:0] addr;
        logic [7:0]  data;
        logic [4:0]  reg_sel;

        // model reset state
        foreach (crtc_shadow[k])
            crtc_shadow[k] = REG_DEFAULTS[k];
        foreach (vram_shadow[k])
            vram_shadow[k] = 8'(k);
        foreach (rom_shadow[k]) begin
            rom_shadow[k] = 8'h00;
            rom_loaded[k] = 1'b0;
        end
        index_shadow = '0;
        bank_shadow  = '0;
        top_shadow   = CUR_TOP_RST;
        bot_shadow   = CUR_BOT_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; o_ready stays low through the RAM preset
        for (row = 0; row < SCRIPT_ROWS; row++)
            push_access(ACCESS_SCRIPT[row].op, ACCESS_SCRIPT[row].addr,
                        ACCESS_SCRIPT[row].data, ACCESS_SCRIPT[row].fixed,
                        ACCESS_SCRIPT[row].result);
        drain_results();

        // random traffic, mostly well-formed register and window sequences
        next_calm  = busy_items + CALM_STRIDE;
        next_drain = busy_items + DRAIN_STRIDE;
        while (busy_items < BUSY_ITEMS) begin
            if (busy_items >= next_calm) begin
                calm = ($urandom_range(0, 3) == 0);
                next_calm += CALM_STRIDE;
            end
            if (busy_items >= next_drain) begin
                drain_results();
                next_drain += DRAIN_STRIDE;
            end
            roll = $urandom_range(0, 99);
            addr = 11'($urandom);
            data = 8'($urandom);
            if (roll < 25) begin
                // register write: select the index, then one or two data writes;
                // cursor and start registers favoured
                reg_sel = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(10, 15))
                                                      : 5'($urandom_range(0, 31));
                addr[0] = 1'b0;
                push_access(OP_IO_WR, addr, {data[7:5], reg_sel}, 1'b0, NO_RESULT);
                burst = $urandom_range(1, 2);
                repeat (burst) begin
                    addr    = 11'($urandom);
                    addr[0] = 1'b1;
                    push_access(OP_IO_WR, addr, 8'($urandom), 1'b0, NO_RESULT);
                end
            end else if (roll < 35) begin
                // register read-back
                reg_sel = 5'($urandom_range(0, 31));
                addr[0] = 1'b0;
                push_access(OP_IO_WR, addr, {data[7:5], reg_sel}, 1'b0, NO_RESULT);
                addr    = 11'($urandom);
                addr[0] = 1'b1;
                push_access(OP_IO_RD, addr, 8'($urandom), 1'b0, NO_RESULT);
            end else if (roll < 40) begin
                // bank change through an I/O read
                push_access(OP_IO_RD, addr, data, 1'b0, NO_RESULT);
            end else if (roll < 65) begin
                // character writes in short runs along the window
                burst = $urandom_range(1, 4);
                addr  = WIN_RAM_LO + 11'($urandom_range(0, 511));
                repeat (burst) begin
                    push_access(OP_WIN_WR, addr, 8'($urandom), 1'b0, NO_RESULT);
                    addr[8:0] = addr[8:0] + 9'd1;
                end
            end else if (roll < 80) begin
                addr = WIN_RAM_LO + 11'($urandom_range(0, 511));
                push_access(OP_WIN_RD, addr, data, 1'b0, NO_RESULT);
            end else if (roll < 88) begin
                // firmware load, half of it into the slot page
                if ($urandom_range(0, 1) == 1)
                    addr[9:8] = SLOT_PAGE[9:8];
                push_access(OP_ROM_LD, addr, data, 1'b0, NO_RESULT);
            end else if (roll < 94) begin
                op = ($urandom_range(0, 1) == 1) ? OP_SLOT_RD : OP_WIN_RD;
                if (op == OP_WIN_RD)
                    addr[10] = 1'b0;
                steer_rom_read(op, addr);
                push_access(op, addr, data, 1'b0, NO_RESULT);
            end else begin
                // noise: any op, any address
                op = 3'($urandom_range(0, 7));
                steer_rom_read(op, addr);
                push_access(op, addr, data, 1'b0, NO_RESULT);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0)
            $display("%0d results never arrived", awaited_results.size());
        if (mismatches == 0 && strays == 0 && awaited_results.size() == 0)
            $display("eighty_column_card_bus_interface_tb OK");
        else
            $display("eighty_column_card_bus_interface_tb NOT OK");
        $finish;
    end

endmodule
